/* rtl/cau_pkg.sv */
// Shared types, constants and helper functions for the complex arithmetic unit.
// No dependencies; cau_stage, the unit and the testbench import this package.
`timescale 1ns / 1ps

package cau_pkg;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV   = 3'd3,
    OP_EQ    = 3'd4,
    OP_NE    = 3'd5,
    OP_MAG   = 3'd6,
    OP_PHASE = 3'd7
  } op_t;

  localparam int DIV_STEPS  = 33;   // quotient bits of the Q16.17 quotient
  localparam int SQRT_STEPS = 32;   // root bits of a 64-bit radicand
  localparam int CW         = 52;   // CORDIC x/y width, prescaled by 2^16 plus growth
  localparam logic signed [31:0] PI_Q16 = 32'sd205887;

  typedef struct packed {
    op_t                  op;
    // results of add, sub, mul, equal and not equal, settled early
    logic [31:0]          side_re;
    logic [31:0]          side_im;
    logic                 side_cmp;
    logic                 side_err;
    // restoring divider, one lane per part
    logic                 dz;
    logic                 neg_re;
    logic                 neg_im;
    logic                 ovf_re;
    logic                 ovf_im;
    logic [63:0]          den;
    logic [63:0]          r_re;
    logic [63:0]          r_im;
    logic [15:0]          lo_re;
    logic [15:0]          lo_im;
    logic [DIV_STEPS-1:0] q_re;
    logic [DIV_STEPS-1:0] q_im;
    // square root
    logic [63:0]          sq_s;
    logic [63:0]          sq_res;
    // CORDIC vectoring
    logic                 chold;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [31:0]   cz;
  } cau_iter_t;

  function automatic logic signed [31:0] atan_q16(input int idx);
    case (idx)
      0:       return 32'sd51472;
      1:       return 32'sd30386;
      2:       return 32'sd16055;
      3:       return 32'sd8150;
      4:       return 32'sd4091;
      5:       return 32'sd2047;
      6:       return 32'sd1024;
      7:       return 32'sd512;
      8:       return 32'sd256;
      9:       return 32'sd128;
      10:      return 32'sd64;
      11:      return 32'sd32;
      12:      return 32'sd16;
      13:      return 32'sd8;
      14:      return 32'sd4;
      15:      return 32'sd2;
      16:      return 32'sd1;
      default: return 32'sd0;
    endcase
  endfunction

  // Sign/magnitude to saturated 32-bit pattern; returns {err, value}.
  function automatic logic [32:0] pack(input logic neg, input logic [63:0] mag);
    logic [63:0] t;
    t = 64'd0 - mag;
    if (neg) begin
      if (mag > 64'h0000_0000_8000_0000) return {1'b1, 32'h8000_0000};
      return {1'b0, t[31:0]};
    end
    if (mag > 64'h0000_0000_7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
    return {1'b0, mag[31:0]};
  endfunction

  // Saturate a 33-bit sum to 32 bits; returns {err, value}.
  function automatic logic [32:0] sat33(input logic [32:0] v);
    if (v[32] != v[31]) return {1'b1, v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF};
    return {1'b0, v[31:0]};
  endfunction

  // Sum of two terms in [-2^62, 2^62] as {neg, magnitude}.
  function automatic logic [64:0] sum2(input logic [63:0] p, input logic [63:0] q);
    logic [63:0] s;
    s = p + q;
    if (s == 64'h8000_0000_0000_0000) return {1'b0, s};
    if (s[63]) return {1'b1, 64'd0 - s};
    return {1'b0, s};
  endfunction

  function automatic logic [63:0] round16(input logic [63:0] mag);
    return (mag >> 16) + {63'd0, mag[15]};
  endfunction

endpackage

/* rtl/cau_if.sv */
// Valid/ready channel interfaces for operand and result transfers.
// No dependencies.
`timescale 1ns / 1ps

interface cau_op_if;
  logic               valid;
  logic               ready;
  logic [2:0]         operation;
  logic signed [31:0] a_real;
  logic signed [31:0] a_imag;
  logic signed [31:0] b_real;
  logic signed [31:0] b_imag;

  modport source (output valid, operation, a_real, a_imag, b_real, b_imag, input ready);
  modport sink   (input valid, operation, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cau_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] res_real;
  logic signed [31:0] res_imag;
  logic               compare_true;
  logic               error_flag;

  modport source (output valid, res_real, res_imag, compare_true, error_flag, input ready);
  modport sink   (input valid, res_real, res_imag, compare_true, error_flag, output ready);
endinterface

/* rtl/cau_stage.sv */
// One register stage of the iterative section: a divider bit for both parts,
// a square-root bit and a CORDIC turn in early stages. Depends on cau_pkg.
`timescale 1ns / 1ps

module cau_stage import cau_pkg::*; #(
  parameter int STEP         = 0,
  parameter int CORDIC_STEPS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      vin,
  input  cau_iter_t din,
  output logic      vout,
  output cau_iter_t dout
);

  localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * (STEP % SQRT_STEPS));
  localparam logic signed [31:0] ATAN = atan_q16(STEP);

  cau_iter_t            nxt;
  logic [63:0]          r2_re;
  logic [63:0]          r2_im;
  logic [63:0]          trial;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;

  always_comb begin
    nxt   = din;
    r2_re = {din.r_re[62:0], din.lo_re[15]};
    r2_im = {din.r_im[62:0], din.lo_im[15]};
    trial = din.sq_res + SQ_BIT;
    dx    = $signed(din.cy) >>> STEP;
    dy    = $signed(din.cx) >>> STEP;

    nxt.lo_re = {din.lo_re[14:0], 1'b0};
    nxt.lo_im = {din.lo_im[14:0], 1'b0};
    if (r2_re >= din.den) begin
      nxt.r_re = r2_re - din.den;
      nxt.q_re = {din.q_re[DIV_STEPS-2:0], 1'b1};
    end else begin
      nxt.r_re = r2_re;
      nxt.q_re = {din.q_re[DIV_STEPS-2:0], 1'b0};
    end
    if (r2_im >= din.den) begin
      nxt.r_im = r2_im - din.den;
      nxt.q_im = {din.q_im[DIV_STEPS-2:0], 1'b1};
    end else begin
      nxt.r_im = r2_im;
      nxt.q_im = {din.q_im[DIV_STEPS-2:0], 1'b0};
    end

    if (STEP < SQRT_STEPS) begin
      if (din.sq_s >= trial) begin
        nxt.sq_s   = din.sq_s - trial;
        nxt.sq_res = (din.sq_res >> 1) + SQ_BIT;
      end else begin
        nxt.sq_res = din.sq_res >> 1;
      end
    end

    // rotate toward the positive real axis
    if (STEP < CORDIC_STEPS && !din.chold) begin
      if (!din.cy[CW-1] && din.cy != '0) begin
        nxt.cx = din.cx + dx;
        nxt.cy = din.cy - dy;
        nxt.cz = din.cz + ATAN;
      end else begin
        nxt.cx = din.cx - dx;
        nxt.cy = din.cy + dy;
        nxt.cz = din.cz - ATAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

/* rtl/complex_arithmetic_unit.sv */
// Complex arithmetic unit, signed Q16.16: add, sub, mul, div, compare,
// magnitude and phase. Depends on cau_pkg, cau_if and cau_stage.
//
//   channel    modport  carries
//   operands   sink     operation, a_real, a_imag, b_real, b_imag
//   results    source   res_real, res_imag, compare_true, error_flag
//
// One transfer in per cycle while operands.ready is high. Each result passes
// the multiply, sum and prepare stages, the 33-bit restoring divider (one
// quotient bit per stage), then the finish and output stages.
// rst is synchronous and clears only valid bits.
// A skid register behind the output parks one more result while a result
// waits; the whole pipe then holds until the skid register empties.
`timescale 1ns / 1ps

module complex_arithmetic_unit import cau_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input logic        clk,
  input logic        rst,
  cau_op_if.sink     operands,
  cau_res_if.source  results
);

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic        cmp;
    logic        err;
  } res_t;

  logic en;

  // ---------------- stage 1: products, add/sub, compare
  logic               v1;
  op_t                op1;
  logic signed [31:0] ar1;
  logic signed [31:0] ai1;
  logic signed [63:0] p_arbr, p_aibi, p_arbi, p_aibr;
  logic signed [63:0] p_brbr, p_bibi, p_arar, p_aiai;
  logic [31:0]        s1_re, s1_im;
  logic               s1_cmp, s1_err;

  op_t         op_in;
  logic [32:0] add_re, add_im, sub_re, sub_im;
  logic [32:0] sat_re, sat_im;
  logic        eq_in;
  logic [31:0] s_re, s_im;
  logic        s_cmp, s_err;

  always_comb begin
    op_in  = op_t'(operands.operation);
    add_re = {operands.a_real[31], operands.a_real} + {operands.b_real[31], operands.b_real};
    add_im = {operands.a_imag[31], operands.a_imag} + {operands.b_imag[31], operands.b_imag};
    sub_re = {operands.a_real[31], operands.a_real} - {operands.b_real[31], operands.b_real};
    sub_im = {operands.a_imag[31], operands.a_imag} - {operands.b_imag[31], operands.b_imag};
    eq_in  = (operands.a_real == operands.b_real) && (operands.a_imag == operands.b_imag);
    sat_re = '0;
    sat_im = '0;
    s_cmp  = 1'b0;
    case (op_in)
      OP_ADD: begin
        sat_re = sat33(add_re);
        sat_im = sat33(add_im);
      end
      OP_SUB: begin
        sat_re = sat33(sub_re);
        sat_im = sat33(sub_im);
      end
      OP_EQ:   s_cmp = eq_in;
      OP_NE:   s_cmp = !eq_in;
      default: s_cmp = 1'b0;
    endcase
    s_re  = sat_re[31:0];
    s_im  = sat_im[31:0];
    s_err = sat_re[32] | sat_im[32];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= operands.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1    <= op_in;
      ar1    <= operands.a_real;
      ai1    <= operands.a_imag;
      p_arbr <= operands.a_real * operands.b_real;
      p_aibi <= operands.a_imag * operands.b_imag;
      p_arbi <= operands.a_real * operands.b_imag;
      p_aibr <= operands.a_imag * operands.b_real;
      p_brbr <= operands.b_real * operands.b_real;
      p_bibi <= operands.b_imag * operands.b_imag;
      p_arar <= operands.a_real * operands.a_real;
      p_aiai <= operands.a_imag * operands.a_imag;
      s1_re  <= s_re;
      s1_im  <= s_im;
      s1_cmp <= s_cmp;
      s1_err <= s_err;
    end
  end

  // ---------------- stage 2: wide sums, CORDIC setup
  logic                 v2;
  op_t                  op2;
  logic [31:0]          s2_re, s2_im;
  logic                 s2_cmp, s2_err;
  logic [64:0]          m2_re, m2_im, d2_re, d2_im;
  logic [63:0]          den2, sqs2;
  logic                 chold2;
  logic signed [CW-1:0] cx2, cy2;
  logic signed [31:0]   cz2;

  logic                 chold_n;
  logic signed [CW-1:0] tx, ty;
  logic signed [31:0]   tz;

  always_comb begin
    tx      = {{(CW-48){ar1[31]}}, ar1, 16'd0};
    ty      = {{(CW-48){ai1[31]}}, ai1, 16'd0};
    tz      = '0;
    chold_n = 1'b0;
    if (ai1 == '0) begin
      // on the real axis: zero or exactly pi
      chold_n = 1'b1;
      tz      = ar1[31] ? PI_Q16 : 32'sd0;
    end else if (tx[CW-1]) begin
      tz = ty[CW-1] ? -PI_Q16 : PI_Q16;
      tx = -tx;
      ty = -ty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op2    <= op1;
      s2_re  <= s1_re;
      s2_im  <= s1_im;
      s2_cmp <= s1_cmp;
      s2_err <= s1_err;
      m2_re  <= sum2(p_arbr, 64'd0 - p_aibi);
      m2_im  <= sum2(p_arbi, p_aibr);
      d2_re  <= sum2(p_arbr, p_aibi);
      d2_im  <= sum2(p_aibr, 64'd0 - p_arbi);
      den2   <= p_brbr + p_bibi;
      sqs2   <= p_arar + p_aiai;
      chold2 <= chold_n;
      cx2    <= tx;
      cy2    <= ty;
      cz2    <= tz;
    end
  end

  // ---------------- stage 3: finish mul, set up divider and root
  logic        v3;
  cau_iter_t   it3;
  cau_iter_t   it3_n;
  logic [32:0] pk_re, pk_im;

  always_comb begin
    pk_re         = pack(m2_re[64], round16(m2_re[63:0]));
    pk_im         = pack(m2_im[64], round16(m2_im[63:0]));
    it3_n         = '0;
    it3_n.op      = op2;
    it3_n.side_re = s2_re;
    it3_n.side_im = s2_im;
    it3_n.side_cmp = s2_cmp;
    it3_n.side_err = s2_err;
    if (op2 == OP_MUL) begin
      it3_n.side_re  = pk_re[31:0];
      it3_n.side_im  = pk_im[31:0];
      it3_n.side_err = pk_re[32] | pk_im[32];
    end
    it3_n.dz     = (den2 == '0);
    it3_n.neg_re = d2_re[64];
    it3_n.neg_im = d2_im[64];
    // quotient of 2^33 or more in Q16.17 saturates
    it3_n.ovf_re = (den2[63:48] == '0) && (d2_re[63:0] >= {den2[47:0], 16'd0});
    it3_n.ovf_im = (den2[63:48] == '0) && (d2_im[63:0] >= {den2[47:0], 16'd0});
    it3_n.den    = den2;
    it3_n.r_re   = d2_re[63:0] >> 16;
    it3_n.r_im   = d2_im[63:0] >> 16;
    it3_n.lo_re  = d2_re[15:0];
    it3_n.lo_im  = d2_im[15:0];
    it3_n.sq_s   = sqs2;
    it3_n.chold  = chold2;
    it3_n.cx     = cx2;
    it3_n.cy     = cy2;
    it3_n.cz     = cz2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it3 <= it3_n;
    end
  end

  // ---------------- iterative section
  logic      stg_v [DIV_STEPS+1];
  cau_iter_t stg_d [DIV_STEPS+1];

  assign stg_v[0] = v3;
  assign stg_d[0] = it3;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    cau_stage #(
      .STEP         (k),
      .CORDIC_STEPS (CORDIC_STEPS)
    ) u_stage (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .vin  (stg_v[k]),
      .din  (stg_d[k]),
      .vout (stg_v[k+1]),
      .dout (stg_d[k+1])
    );
  end

  // ---------------- finish stage
  cau_iter_t   f;
  res_t        fin_n;
  res_t        fin;
  logic        v_end;
  logic [63:0] qr_re, qr_im, root;
  logic [32:0] dq_re, dq_im, pk_root;

  always_comb begin
    f       = stg_d[DIV_STEPS];
    qr_re   = ({{(64-DIV_STEPS){1'b0}}, f.q_re} + 64'd1) >> 1;
    qr_im   = ({{(64-DIV_STEPS){1'b0}}, f.q_im} + 64'd1) >> 1;
    dq_re   = f.ovf_re ? pack(f.neg_re, 64'd1 << 40) : pack(f.neg_re, qr_re);
    dq_im   = f.ovf_im ? pack(f.neg_im, 64'd1 << 40) : pack(f.neg_im, qr_im);
    root    = f.sq_res + {63'd0, (f.sq_s > f.sq_res)};
    pk_root = pack(1'b0, root);
    fin_n   = '0;
    case (f.op)
      OP_DIV: begin
        if (f.dz) begin
          fin_n.err = 1'b1;
        end else begin
          fin_n.re  = dq_re[31:0];
          fin_n.im  = dq_im[31:0];
          fin_n.err = dq_re[32] | dq_im[32];
        end
      end
      OP_MAG: begin
        fin_n.re  = pk_root[31:0];
        fin_n.err = pk_root[32];
      end
      OP_PHASE: fin_n.re = f.cz;
      default: begin
        fin_n.re  = f.side_re;
        fin_n.im  = f.side_im;
        fin_n.cmp = f.side_cmp;
        fin_n.err = f.side_err;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_end <= 1'b0;
    end else if (en) begin
      v_end <= stg_v[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin <= fin_n;
    end
  end

  // ---------------- output register with skid
  logic out_v, sk_v;
  res_t out_d, sk_d;
  logic leave;

  assign en             = !sk_v;
  assign leave          = en && v_end;
  assign operands.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
      sk_v  <= 1'b0;
    end else if (!out_v || results.ready) begin
      if (sk_v) begin
        out_v <= 1'b1;
        sk_v  <= 1'b0;
      end else begin
        out_v <= leave;
      end
    end else if (leave) begin
      // output stalled: park the arriving result
      sk_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v || results.ready) begin
      if (sk_v) begin
        out_d <= sk_d;
      end else if (leave) begin
        out_d <= fin;
      end
    end else if (leave) begin
      sk_d <= fin;
    end
  end

  assign results.valid        = out_v;
  assign results.res_real     = out_d.re;
  assign results.res_imag     = out_d.im;
  assign results.compare_true = out_d.cmp;
  assign results.error_flag   = out_d.err;

  // ---------------- assertions
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    sk_v |-> out_v)
    else $error("skid register full while output register empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(sk_v) |-> $past(out_v && !results.ready))
    else $error("skid register filled without an output stall");

  a_compare_clean: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.compare_true |->
      !results.error_flag && results.res_real == 0 && results.res_imag == 0)
    else $error("compare result carries error or nonzero value");

endmodule

/* tb/complex_arithmetic_unit_tb.sv */
// Testbench for complex_arithmetic_unit: directed and random operand transfers,
// self-predicted results checked in order. Depends on cau_pkg, cau_if and the RTL.
`timescale 1ns / 1ps

module complex_arithmetic_unit_tb;
  import cau_pkg::*;

  typedef struct {
    logic [31:0] re;
    logic [31:0] im;
    logic        cmp;
    logic        err;
  } cau_result_t;

  localparam int LATENCY = 38;

  logic clk;
  logic rst;
  int   mismatches;
  int   sent;
  int   received;
  bit   timed_out;
  bit   rx_stall_mode;

  cau_result_t pending_results[$];

  cau_op_if  operands();
  cau_res_if results();

  complex_arithmetic_unit #(.CORDIC_STEPS(16)) uut (
    .clk(clk), .rst(rst), .operands(operands), .results(results)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #80_000_000;
    timed_out = 1'b1;
    $display("FAILURE");
    $finish;
  end

  // ---------------- predictor ----------------
  function automatic logic [31:0] sat_pack(input logic neg, input logic [63:0] mag,
                                           inout logic err);
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        err = 1'b1;
        return 32'h8000_0000;
      end
      return 32'(64'd0 - mag);
    end
    if (mag > 64'h7FFF_FFFF) begin
      err = 1'b1;
      return 32'h7FFF_FFFF;
    end
    return mag[31:0];
  endfunction

  function automatic logic [31:0] sat_signed(input longint s, inout logic err);
    return sat_pack(s < 0, s < 0 ? 64'(-s) : 64'(s), err);
  endfunction

  // split a two-term sum into sign and magnitude
  function automatic void split_sum(input longint p, input longint q,
                                    output logic neg, output logic [63:0] mag);
    logic [63:0] s;
    s = 64'(p) + 64'(q);
    if (s == 64'h8000_0000_0000_0000) begin
      neg = 1'b0;
      mag = s;
    end else begin
      neg = s[63];
      mag = neg ? 64'd0 - s : s;
    end
  endfunction

  function automatic logic [63:0] round_q16(input logic [63:0] mag);
    return (mag >> 16) + {63'd0, mag[15]};
  endfunction

  function automatic logic [31:0] div_part(input logic [63:0] num, input logic [63:0] den,
                                           input logic neg, inout logic err);
    logic [63:0] q;
    logic [63:0] r;
    q = num / den;
    r = num % den;
    if (q > 64'd32768) return sat_pack(neg, 64'd1 << 40, err);
    for (int i = 0; i < 17; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q[0] = 1'b1;
      end
    end
    return sat_pack(neg, (q + 64'd1) >> 1, err);
  endfunction

  function automatic logic [31:0] magnitude_of(input longint x, input longint y,
                                               inout logic err);
    logic [63:0] s;
    logic [63:0] root;
    logic [63:0] bitv;
    s = 64'(x * x) + 64'(y * y);
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= root + bitv) begin
        s = s - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    if (s > root) root++;
    return sat_pack(1'b0, root, err);
  endfunction

  function automatic longint arctan_step(input int i);
    longint tbl[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256,
                        128, 64, 32, 16, 8, 4, 2, 1};
    return (i < 17) ? tbl[i] : 0;
  endfunction

  function automatic logic [31:0] phase_of(input longint x, input longint y);
    longint z;
    longint dx;
    longint dy;
    z = 0;
    if (y == 0) return (x < 0) ? 32'd205887 : 32'd0;
    x = x * 65536;
    y = y * 65536;
    if (x < 0) begin
      z = (y > 0) ? 205887 : -205887;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;  // arithmetic shift floors
      dy = x >>> i;
      if (y > 0) begin
        x += dx;
        y -= dy;
        z += arctan_step(i);
      end else begin
        x -= dx;
        y += dy;
        z -= arctan_step(i);
      end
    end
    return 32'(z);
  endfunction

  function automatic cau_result_t compute_result(input op_t op, input logic [31:0] ar_b,
      input logic [31:0] ai_b, input logic [31:0] br_b, input logic [31:0] bi_b);
    cau_result_t r;
    longint ar;
    longint ai;
    longint br;
    longint bi;
    logic neg;
    logic [63:0] mag;
    logic [63:0] den;
    logic eq;
    ar = longint'($signed(ar_b));
    ai = longint'($signed(ai_b));
    br = longint'($signed(br_b));
    bi = longint'($signed(bi_b));
    r = '{re: 0, im: 0, cmp: 0, err: 0};
    eq = (ar == br) && (ai == bi);
    case (op)
      OP_ADD: begin
        r.re = sat_signed(ar + br, r.err);
        r.im = sat_signed(ai + bi, r.err);
      end
      OP_SUB: begin
        r.re = sat_signed(ar - br, r.err);
        r.im = sat_signed(ai - bi, r.err);
      end
      OP_MUL: begin
        split_sum(ar * br, -(ai * bi), neg, mag);
        r.re = sat_pack(neg, round_q16(mag), r.err);
        split_sum(ar * bi, ai * br, neg, mag);
        r.im = sat_pack(neg, round_q16(mag), r.err);
      end
      OP_DIV: begin
        den = 64'(br * br) + 64'(bi * bi);
        if (den == 0) begin
          r.err = 1'b1;
        end else begin
          split_sum(ar * br, ai * bi, neg, mag);
          r.re = div_part(mag, den, neg, r.err);
          split_sum(ai * br, -(ar * bi), neg, mag);
          r.im = div_part(mag, den, neg, r.err);
        end
      end
      OP_EQ: r.cmp = eq;
      OP_NE: r.cmp = !eq;
      OP_MAG: r.re = magnitude_of(ar, ai, r.err);
      default: r.re = phase_of(ar, ai);
    endcase
    return r;
  endfunction

  // ---------------- driving and checking ----------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("mismatch on result %0d: %s got %h expected %h", received, what, got, want);
  endtask

  task automatic send_item(input op_t op, input logic [31:0] ar, input logic [31:0] ai,
                           input logic [31:0] br, input logic [31:0] bi);
    operands.valid     <= 1'b1;
    operands.operation <= op;
    operands.a_real    <= ar;
    operands.a_imag    <= ai;
    operands.b_real    <= br;
    operands.b_imag    <= bi;
    pending_results.push_back(compute_result(op, ar, ai, br, bi));
    @(posedge clk);
    while (!operands.ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic idle_cycles(input int n);
    operands.valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain_results();
    operands.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  always @(posedge clk) begin
    cau_result_t want;
    if (!rst && results.valid && results.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", results.res_real, 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (results.res_real !== want.re) report_mismatch("res_real", results.res_real, want.re);
        if (results.res_imag !== want.im) report_mismatch("res_imag", results.res_imag, want.im);
        if (results.compare_true !== want.cmp)
          report_mismatch("compare_true", {31'd0, results.compare_true}, {31'd0, want.cmp});
        if (results.error_flag !== want.err)
          report_mismatch("error_flag", {31'd0, results.error_flag}, {31'd0, want.err});
      end
      received++;
    end
  end

  // receiver: alternate between free-running stretches and random stalls
  always @(negedge clk) begin
    if (rst) begin
      results.ready <= 1'b1;
    end else begin
      if ($urandom_range(0, 63) == 0) rx_stall_mode <= ~rx_stall_mode;
      results.ready <= rx_stall_mode ? ($urandom_range(0, 2) != 0) : 1'b1;
    end
  end

  function automatic logic [31:0] random_part();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      2: return 32'($signed($urandom_range(0, 2000)) - 1000);
      3: return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      4: return 32'd0;
      default: return 32'($signed($urandom_range(0, 512 << 16)) - (256 << 16));
    endcase
  endfunction

  // ---------------- tests ----------------
  task automatic test_extremes();
    logic [31:0] vals[5] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'h0001_0000,
                             32'hFFFF_FFFF};
    for (int o = 0; o < 8; o++) begin
      send_item(op_t'(o), vals[o % 5], vals[(o + 1) % 5], vals[(o + 2) % 5],
                vals[(o + 3) % 5]);
    end
    send_item(OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'hFFFF_FFFF);
    send_item(OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'hFFFF_FFFF);
    send_item(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_item(OP_DIV, 32'h0001_0000, 32'h0002_0000, 32'd0, 32'd0);
    send_item(OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'd0);
    send_item(OP_EQ, 32'h1234_5678, 32'h9ABC_DEF0, 32'h1234_5678, 32'h9ABC_DEF0);
    send_item(OP_NE, 32'h1234_5678, 32'h9ABC_DEF0, 32'h1234_5678, 32'h9ABC_DEF0);
    send_item(OP_NE, 32'h1234_5678, 32'h9ABC_DEF0, 32'h1234_5678, 32'h9ABC_DEF1);
    send_item(OP_MAG, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0);
    send_item(OP_MAG, 32'h0003_0000, 32'h0004_0000, 32'd0, 32'd0);
    send_item(OP_PHASE, 32'd0, 32'd0, 32'd0, 32'd0);
    send_item(OP_PHASE, 32'hFFFF_0000, 32'd0, 32'd0, 32'd0);
    send_item(OP_PHASE, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0, 32'd0);
    send_item(OP_PHASE, 32'h8000_0000, 32'd1, 32'd0, 32'd0);
    send_item(OP_PHASE, 32'd0, 32'h8000_0000, 32'd0, 32'd0);
  endtask

  task automatic test_random_bursts(input int count);
    int n;
    logic [31:0] ar;
    logic [31:0] ai;
    n = 0;
    while (n < count) begin
      repeat ($urandom_range(1, 40)) begin
        ar = random_part();
        ai = random_part();
        // sometimes make b equal to a so the compare ops hit both outcomes
        if ($urandom_range(0, 3) == 0)
          send_item(op_t'($urandom_range(0, 7)), ar, ai, ar, ai);
        else
          send_item(op_t'($urandom_range(0, 7)), ar, ai, random_part(), random_part());
        n++;
      end
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 12));
    end
  endtask

  initial begin
    mismatches = 0;
    sent = 0;
    received = 0;
    timed_out = 1'b0;
    rx_stall_mode = 1'b0;
    rst = 1'b1;
    operands.valid = 1'b0;
    operands.operation = OP_ADD;
    operands.a_real = 0;
    operands.a_imag = 0;
    operands.b_real = 0;
    operands.b_imag = 0;
    results.ready = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_extremes();
    // hold off until the pipe is empty, then restart
    drain_results();
    test_random_bursts(450);
    drain_results();
    test_random_bursts(450);
    drain_results();

    $display("sent %0d operand transfers over all eight operations; %0d results checked",
             sent, received);
    if (mismatches == 0 && !timed_out) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* complex_arithmetic_unit.f */
rtl/cau_pkg.sv
rtl/cau_if.sv
rtl/cau_stage.sv
rtl/complex_arithmetic_unit.sv
tb/complex_arithmetic_unit_tb.sv
